// ===== hw/rtl/largest_prime_factor_macros.svh =====
// Assertion macros for the largest prime factor block.
// Used by the port checker; depends on nothing else.
`ifndef LARGEST_PRIME_FACTOR_MACROS_SVH
`define LARGEST_PRIME_FACTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define LPF_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define LPF_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lpf_pkg.sv =====
// Shared constants and control types for the largest prime factor block.
// No dependencies.
`timescale 1ns / 1ps

package lpf_pkg;

  localparam int IN_BITS        = 40;
  localparam int OUT_BITS       = 40;
  localparam int DEF_VALUE_BITS = 40;
  localparam int FIRST_DIV      = 2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_start;
    logic take;
    logic next_div;
    logic finish;
  } lpf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic below_two;
    logic div_done;
    logic stop;
    logic exact;
  } lpf_sts_t;

endpackage

// ===== hw/rtl/lpf_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Takes its default width from lpf_pkg.
`timescale 1ns / 1ps

module lpf_div import lpf_pkg::*; #(
  parameter int W = DEF_VALUE_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] quo,
  output logic [W-1:0] rem,
  output logic         done
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    rem_sh;
  logic [W+1:0]  diff;

  always_comb begin
    rem_sh   = {rem_r, quo_r[W-1]};
    diff     = {1'b0, rem_sh} - {2'b00, divisor};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = CW'(W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      // The partial remainder always stays below the divisor, so W bits hold it.
      if (diff[W+1]) begin
        rem_nxt = rem_sh[W-1:0];
      end else begin
        rem_nxt = diff[W-1:0];
      end
      quo_nxt = {quo_r[W-2:0], ~diff[W+1]};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign quo  = quo_r;
  assign rem  = rem_r;
  assign done = done_r;

endmodule

// ===== hw/rtl/lpf_dp.sv =====
// Datapath: remaining value, trial divisor, best factor and result registers.
// Depends on lpf_pkg and lpf_div.
`timescale 1ns / 1ps

module lpf_dp import lpf_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lpf_cmd_t            cmd,
  output lpf_sts_t            sts,
  input  logic [IN_BITS-1:0]  in_value,
  output logic [OUT_BITS-1:0] out_largest_factor,
  output logic                out_value_is_prime
);

  localparam logic [VALUE_BITS-1:0] TWO   = VALUE_BITS'(FIRST_DIV);
  localparam logic [VALUE_BITS-1:0] THREE = VALUE_BITS'(FIRST_DIV + 1);

  logic [VALUE_BITS-1:0] v_r, v_nxt;
  logic [VALUE_BITS-1:0] rest_r, rest_nxt;
  logic [VALUE_BITS-1:0] best_r, best_nxt;
  logic [VALUE_BITS-1:0] d_r, d_nxt;
  logic [VALUE_BITS-1:0] fact_r, fact_nxt;
  logic                  prime_r, prime_nxt;
  logic [VALUE_BITS-1:0] quo, rem;
  logic                  div_done;
  logic [VALUE_BITS-1:0] final_f;

  lpf_div #(.W(VALUE_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (rest_r),
    .divisor  (d_r),
    .quo      (quo),
    .rem      (rem),
    .done     (div_done)
  );

  always_comb begin
    final_f   = (rest_r > VALUE_BITS'(1)) ? rest_r : best_r;
    v_nxt     = v_r;
    rest_nxt  = rest_r;
    best_nxt  = best_r;
    d_nxt     = d_r;
    fact_nxt  = fact_r;
    prime_nxt = prime_r;
    if (cmd.load) begin
      v_nxt    = VALUE_BITS'(in_value);
      rest_nxt = VALUE_BITS'(in_value);
      best_nxt = VALUE_BITS'(1);
      d_nxt    = TWO;
    end
    if (cmd.take) begin
      rest_nxt = quo;
      best_nxt = d_r;
    end
    if (cmd.next_div) begin
      d_nxt = (d_r == TWO) ? THREE : d_r + TWO;
    end
    if (cmd.finish) begin
      fact_nxt  = final_f;
      prime_nxt = (v_r >= TWO) && (final_f == v_r);
    end
  end

  always_ff @(posedge clk) begin
    v_r     <= v_nxt;
    rest_r  <= rest_nxt;
    best_r  <= best_nxt;
    d_r     <= d_nxt;
    fact_r  <= fact_nxt;
    prime_r <= prime_nxt;
  end

  // Comparing the divisor with the quotient avoids forming its square.
  assign sts.below_two = rest_r < TWO;
  assign sts.div_done  = div_done;
  assign sts.stop      = d_r > quo;
  assign sts.exact     = rem == '0;

  assign out_largest_factor = OUT_BITS'(fact_r);
  assign out_value_is_prime = prime_r;

endmodule

// ===== hw/rtl/lpf_ctrl.sv =====
// Controller state machine sequencing the trial-division loop.
// Depends on lpf_pkg for the command and status types.
`timescale 1ns / 1ps

module lpf_ctrl import lpf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output logic     out_valid,
  output lpf_cmd_t cmd,
  input  lpf_sts_t sts
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;

  logic [2:0] state_r, state_nxt;
  logic       valid_r, valid_nxt;

  always_comb begin
    state_nxt = state_r;
    valid_nxt = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.below_two) begin
          cmd.finish = 1'b1;
          valid_nxt  = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.stop) begin
          cmd.finish = 1'b1;
          valid_nxt  = 1'b1;
          state_nxt  = S_IDLE;
        end else if (sts.exact) begin
          // Divide the factor out and try the same divisor again.
          cmd.take  = 1'b1;
          state_nxt = S_CHECK;
        end else begin
          cmd.next_div = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = valid_r;

endmodule

// ===== hw/rtl/largest_prime_factor.sv =====
// Channel   Ports                                     Handshake
// input     in_value                                  accepted when start & !busy
// result    out_largest_factor, out_value_is_prime    one-cycle out_valid strobe
//
// Each trial divisor passes through S_CHECK, S_DIV and S_EVAL; S_DIV waits on the
// bit-serial divider. A remaining value below two ends the search at S_CHECK;
// otherwise divisors two, three, five and so on are tried until one exceeds the
// quotient, and busy stays high until the search ends.
// The result word appears the cycle after the search ends; busy is already low then.
// Synchronous active-low reset clears the controller; no clearing pass is needed.
// The receiver cannot stall, so each result is flagged by out_valid for one cycle only.
`timescale 1ns / 1ps

module largest_prime_factor import lpf_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [IN_BITS-1:0]  in_value,
  output logic                out_valid,
  output logic [OUT_BITS-1:0] out_largest_factor,
  output logic                out_value_is_prime
);

  lpf_cmd_t cmd;
  lpf_sts_t sts;

  lpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  lpf_dp #(.VALUE_BITS(VALUE_BITS)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_value           (in_value),
    .out_largest_factor (out_largest_factor),
    .out_value_is_prime (out_value_is_prime)
  );

endmodule

// ===== hw/rtl/lpf_checker.sv =====
// Port-level checker for the largest prime factor block, bound to the top level.
// Depends on lpf_pkg and largest_prime_factor_macros.svh.
`timescale 1ns / 1ps
`include "largest_prime_factor_macros.svh"

module lpf_checker import lpf_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic [IN_BITS-1:0]  in_value,
  input logic                out_valid,
  input logic [OUT_BITS-1:0] out_largest_factor,
  input logic                out_value_is_prime
);

  logic in_word_taken;
  assign in_word_taken = start && !busy && (in_value == in_value);

  `LPF_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_word_taken, busy, "busy not raised after accept")
  `LPF_ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid, !out_valid, "result strobe held over two cycles")
  `LPF_ASSERT_NOW(a_result_after_work, clk, rst_n, out_valid, $past(busy), "result word without preceding work")
  `LPF_ASSERT_NOW(a_prime_factor_range, clk, rst_n, out_valid && out_value_is_prime, out_largest_factor >= OUT_BITS'(2), "prime flag with factor below two")

endmodule

bind largest_prime_factor lpf_checker u_lpf_checker (.*);
